@@ src/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked and gated by the active-low reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    `CHK_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ src/i2c_sdc_pkg.sv @@
// -----------------------------------------------------------------------------
// i2c_sdc_pkg
// Shared widths, constants and divider handshake types for the SCL divider calc.
// -----------------------------------------------------------------------------
package i2c_sdc_pkg;

    localparam int IN_CLK_W = 30;
    localparam int RATE_W   = 22;
    localparam int PRESC_W  = 8;
    localparam int WORD_W   = 32;

    localparam int DIVD_W   = IN_CLK_W;
    localparam int DIVS_W   = 24;
    localparam int CNT_W    = $clog2(DIVD_W);

    localparam int S_TDATA_W = ((IN_CLK_W + RATE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PRESC_W + 2 * WORD_W + 7) / 8) * 8;

    localparam int PRESCALER_LIMIT_DEF = 255;

    localparam logic [RATE_W-1:0] STD_MODE_MAX_HZ  = RATE_W'(100000);
    localparam logic [RATE_W-1:0] FAST_MODE_MAX_HZ = RATE_W'(400000);

    // clk/(p+1) <= target + 1 MHz  <=>  clk < (target + 1 MHz + 1) * (p+1)
    localparam logic [DIVS_W-1:0] SCALE_DIV_SLOW = DIVS_W'(4000000 + 1000000 + 1);
    localparam logic [DIVS_W-1:0] SCALE_DIV_FAST = DIVS_W'(12000000 + 1000000 + 1);

    localparam logic [WORD_W-1:0] LOW_OFFSET  = WORD_W'(7);
    localparam logic [WORD_W-1:0] HIGH_OFFSET = WORD_W'(5);
    localparam int                HS_SHIFT    = 8;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [DIVS_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ src/i2c_sdc_divider.sv @@
// -----------------------------------------------------------------------------
// i2c_sdc_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by all steps.
// -----------------------------------------------------------------------------
module i2c_sdc_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2c_sdc_pkg::t_div_req i_req,
    output i2c_sdc_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [i2c_sdc_pkg::CNT_W-1:0]       r_cnt;
    logic [i2c_sdc_pkg::DIVD_W-1:0]      r_quo;
    logic [i2c_sdc_pkg::DIVS_W-1:0]      r_rem;
    logic [i2c_sdc_pkg::DIVS_W-1:0]      r_dvs;

    logic [i2c_sdc_pkg::DIVS_W:0]        rem_sh;
    logic [i2c_sdc_pkg::DIVS_W+1:0]      diff;
    logic                                ge;
    logic [i2c_sdc_pkg::DIVS_W-1:0]      n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[i2c_sdc_pkg::DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = !diff[i2c_sdc_pkg::DIVS_W+1];
        n_rem  = ge ? diff[i2c_sdc_pkg::DIVS_W-1:0] : rem_sh[i2c_sdc_pkg::DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == i2c_sdc_pkg::CNT_W'(i2c_sdc_pkg::DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[i2c_sdc_pkg::DIVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

@@ src/i2c_scl_divider_calc.sv @@
// -----------------------------------------------------------------------------
// i2c_scl_divider_calc
// I2C SCL prescaler and low/high time word calculator.
// -----------------------------------------------------------------------------
//  channel  dir  width  beat contents (low bit first)
//  s_axis   in   56     func_clk_hz[29:0], bit_rate_hz[51:30]
//  m_axis   out  72     prescaler[7:0], scl_low_word[39:8], scl_high_word[71:40]
//
//  One beat in, one beat out. Up to three passes through the shared
//  radix-2 divider: clk/(target+1MHz+1), clk/(p+1) (clk/p if p is clamped), scaled/bit_rate.
//  Bit rates up to 400 kHz use all three; higher rates divide clk by bit_rate once.
//  s_axis_tready is high only while the sequencer is idle.
//  A finished result waits in the output register; a new beat is taken meanwhile.
//  Synchronous active-low reset clears sequencer, divider and output valid.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_scl_divider_calc #(
    parameter int PRESCALER_LIMIT = i2c_sdc_pkg::PRESCALER_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // func_clk_hz[29:0], bit_rate_hz[51:30], zero pad
    input  logic [i2c_sdc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // prescaler[7:0], scl_low_word[39:8], scl_high_word[71:40]
    output logic [i2c_sdc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_P = 3'd1;
    localparam logic [2:0] ST_DIV_S = 3'd2;
    localparam logic [2:0] ST_DIV_R = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [i2c_sdc_pkg::DIVD_W-1:0]  LIMIT_Q = i2c_sdc_pkg::DIVD_W'(PRESCALER_LIMIT);
    localparam logic [i2c_sdc_pkg::PRESC_W-1:0] LIMIT_P = i2c_sdc_pkg::PRESC_W'(PRESCALER_LIMIT);

    logic [2:0]                          r_state;
    logic [i2c_sdc_pkg::IN_CLK_W-1:0]    r_clk;
    logic [i2c_sdc_pkg::RATE_W-1:0]      r_rate;
    logic                                r_hs;
    logic [i2c_sdc_pkg::PRESC_W-1:0]     r_presc;
    logic [i2c_sdc_pkg::DIVD_W-1:0]      r_ceil;
    logic                                r_div_start;
    logic [i2c_sdc_pkg::DIVD_W-1:0]      r_div_dvd;
    logic [i2c_sdc_pkg::DIVS_W-1:0]      r_div_dvs;
    i2c_sdc_pkg::t_div_req               div_req;
    i2c_sdc_pkg::t_div_rsp               div_rsp;

    logic                                r_out_valid;
    logic [i2c_sdc_pkg::PRESC_W-1:0]     r_out_presc;
    logic [i2c_sdc_pkg::WORD_W-1:0]      r_out_low;
    logic [i2c_sdc_pkg::WORD_W-1:0]      r_out_high;

    logic [i2c_sdc_pkg::IN_CLK_W-1:0]    in_clk;
    logic [i2c_sdc_pkg::RATE_W-1:0]      in_rate;
    logic                                in_hs;
    logic                                in_slow;
    logic                                in_acc;
    logic                                out_free;
    logic [i2c_sdc_pkg::DIVD_W-1:0]      half_hi;
    logic [i2c_sdc_pkg::DIVD_W-1:0]      half_lo;
    logic [i2c_sdc_pkg::WORD_W-1:0]      n_low;
    logic [i2c_sdc_pkg::WORD_W-1:0]      n_high;

    assign div_req = {r_div_start, r_div_dvd, r_div_dvs};

    i2c_sdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        in_clk  = s_axis_tdata[i2c_sdc_pkg::IN_CLK_W-1:0];
        in_rate = s_axis_tdata[i2c_sdc_pkg::IN_CLK_W +: i2c_sdc_pkg::RATE_W];
        if (in_rate == '0) begin
            in_rate = i2c_sdc_pkg::RATE_W'(1);
        end
        in_hs    = in_rate > i2c_sdc_pkg::FAST_MODE_MAX_HZ;
        in_slow  = in_rate <= i2c_sdc_pkg::STD_MODE_MAX_HZ;
        in_acc   = s_axis_tvalid && s_axis_tready;
        out_free = !r_out_valid || m_axis_tready;

        half_hi = {1'b0, r_ceil[i2c_sdc_pkg::DIVD_W-1:1]};
        half_lo = r_ceil - half_hi;
        n_low   = i2c_sdc_pkg::WORD_W'(half_lo) - i2c_sdc_pkg::LOW_OFFSET;
        n_high  = i2c_sdc_pkg::WORD_W'(half_hi) - i2c_sdc_pkg::HIGH_OFFSET;
        if (r_hs) begin
            n_low  = n_low << i2c_sdc_pkg::HS_SHIFT;
            n_high = n_high << i2c_sdc_pkg::HS_SHIFT;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_div_start <= 1'b1;
                        r_state     <= in_hs ? ST_DIV_R : ST_DIV_P;
                    end
                end
                ST_DIV_P: begin
                    if (div_rsp.done) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_S;
                    end
                end
                ST_DIV_S: begin
                    if (div_rsp.done) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_R;
                    end
                end
                ST_DIV_R: begin
                    if (div_rsp.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_clk     <= in_clk;
                    r_rate    <= in_rate;
                    r_hs      <= in_hs;
                    r_presc   <= '0;
                    r_div_dvd <= in_clk;
                    if (in_hs) begin
                        r_div_dvs <= i2c_sdc_pkg::DIVS_W'(in_rate);
                    end else if (in_slow) begin
                        r_div_dvs <= i2c_sdc_pkg::SCALE_DIV_SLOW;
                    end else begin
                        r_div_dvs <= i2c_sdc_pkg::SCALE_DIV_FAST;
                    end
                end
            end
            ST_DIV_P: begin
                if (div_rsp.done) begin
                    r_div_dvd <= r_clk;
                    if (div_rsp.quot >= LIMIT_Q) begin
                        r_presc   <= LIMIT_P;
                        r_div_dvs <= i2c_sdc_pkg::DIVS_W'(LIMIT_P);
                    end else begin
                        r_presc   <= div_rsp.quot[i2c_sdc_pkg::PRESC_W-1:0];
                        r_div_dvs <= i2c_sdc_pkg::DIVS_W'(div_rsp.quot) + 1'b1;
                    end
                end
            end
            ST_DIV_S: begin
                if (div_rsp.done) begin
                    r_div_dvd <= div_rsp.quot;
                    r_div_dvs <= i2c_sdc_pkg::DIVS_W'(r_rate);
                end
            end
            ST_DIV_R: begin
                if (div_rsp.done) begin
                    r_ceil <= div_rsp.quot + i2c_sdc_pkg::DIVD_W'(div_rsp.rem != '0);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_presc <= r_presc;
                    r_out_low   <= n_low;
                    r_out_high  <= n_high;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_high, r_out_low, r_out_presc};

    `CHK_IMPLY(a_idle_div_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !div_rsp.busy, "divider busy while idle")
    `CHK_IMPLY(a_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == ST_DIV_P || r_state == ST_DIV_S || r_state == ST_DIV_R, "divider done outside a division step")
    `CHK_IMPLY(a_start_free, i_clk, i_rst_n, r_div_start, !div_rsp.busy, "divider started while busy")
    `CHK_IMPLY(a_hs_presc, i_clk, i_rst_n, r_state == ST_DONE && r_hs, r_presc == '0, "nonzero prescaler in high-speed mode")
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_low), "stalled result changed")

endmodule
